/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check post in the same cycle as pre.
`define HKV_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("hkv assertion failed");

// Check post in the cycle after pre.
`define HKV_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("hkv assertion failed");

`endif

/* hdl/hkv_pkg.sv */
// ----------------------------------------------------------------------------
// hkv_pkg
// Types, codes and the hash fold step of the hashed key/value store.
// ----------------------------------------------------------------------------
package hkv_pkg;

    localparam int BUCKET_COUNT    = 256;
    localparam int BUCKET_W        = 8;
    localparam int KEY_W           = 64;
    localparam int VALUE_W         = 64;
    localparam int HASH_ACC_W      = 12;
    localparam logic [HASH_ACC_W-1:0] HASH_TOP_MASK = 12'hf00;
    localparam int HASH_FOLD_SHIFT = 8;
    localparam int HASH_BYTES_PER_STEP = 2;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HASH,
        S_FILL,
        S_DISPATCH,
        S_SEARCH,
        S_COMPARE,
        S_SHIFT,
        S_MOVE,
        S_DONE
    } state_t;

    // One PJW-style fold step on a 12-bit accumulator.
    function automatic logic [HASH_ACC_W-1:0] hash_fold(
        input logic [HASH_ACC_W-1:0] acc,
        input logic [7:0]            data
    );
        logic [HASH_ACC_W-1:0] a;
        logic [HASH_ACC_W-1:0] top;
        a   = {acc[7:0], 4'h0} + {4'h0, data};
        top = a & HASH_TOP_MASK;
        if (top != '0)
        begin
            a = a ^ (top >> HASH_FOLD_SHIFT) ^ top;
        end
        return a;
    endfunction

endpackage

/* hdl/hkv_req_if.sv */
// ----------------------------------------------------------------------------
// hkv_req_if
// Request channel: action, key and value with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface hkv_req_if;

    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [63:0] key;
    logic [63:0] value;

    modport source (output valid, output action, output key, output value, input ready);
    modport sink   (input valid, input action, input key, input value, output ready);

endinterface

/* hdl/hkv_rsp_if.sv */
// ----------------------------------------------------------------------------
// hkv_rsp_if
// Response channel: status and found value with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface hkv_rsp_if;

    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] found_value;

    modport source (output valid, output status, output found_value, input ready);
    modport sink   (input valid, input status, input found_value, output ready);

endinterface

/* hdl/hkv_hash.sv */
// ----------------------------------------------------------------------------
// hkv_hash
// Iterative bucket hash: folds two key bytes per cycle, lowest byte first.
// ----------------------------------------------------------------------------
module hkv_hash (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [63:0]             key,
    output logic                    done,
    output logic [hkv_pkg::BUCKET_W-1:0] bucket
);
    import hkv_pkg::*;

    localparam int STEPS  = KEY_W / (8 * HASH_BYTES_PER_STEP);
    localparam int STEP_W = $clog2(STEPS);

    logic [KEY_W-1:0]      shift_reg;
    logic [HASH_ACC_W-1:0] acc_reg;
    logic [HASH_ACC_W-1:0] acc_next;
    logic [STEP_W-1:0]     step_reg;
    logic                  busy_reg;
    logic                  done_reg;

    // two dependent fold steps on the low bytes of the shift register
    always_comb
    begin
        acc_next = hash_fold(acc_reg, shift_reg[7:0]);
        acc_next = hash_fold(acc_next, shift_reg[15:8]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= key;
            acc_reg   <= '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= shift_reg >> (8 * HASH_BYTES_PER_STEP);
            acc_reg   <= acc_next;
        end
    end

    // the fold keeps the accumulator below the bucket count
    assign bucket = acc_reg[BUCKET_W-1:0];
    assign done   = done_reg;

endmodule

/* hdl/hashed_key_value_store_top.sv */
// ----------------------------------------------------------------------------
// hashed_key_value_store_top
// Key/value store over 256 hashed buckets of BUCKET_WAYS ordered entries.
// Sequence: hash the key, read the bucket fill, dispatch; an add writes at
//   the tail, lookup and remove search one way at a time, and a remove that
//   hits moves each later entry one way forward, then the response is sent.
// Throughput: one request at a time; the hash unit and the single read port
//   of the entry memories set the pace.
// Reset: asynchronous, active low; clears the bucket fill valid bits, so all
//   buckets read empty at once. Entry memories are not cleared.
// ----------------------------------------------------------------------------
module hashed_key_value_store_top #(
    parameter int BUCKET_WAYS = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    hkv_req_if.sink   req,
    hkv_rsp_if.source rsp
);
    import hkv_pkg::*;

    localparam int FILL_W = $clog2(BUCKET_WAYS + 1);
    localparam int DEPTH  = BUCKET_COUNT * BUCKET_WAYS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] WAYS_A = ADDR_W'(BUCKET_WAYS);
    localparam logic [FILL_W-1:0] WAYS_F = FILL_W'(BUCKET_WAYS);

    // Sequencer state and captured request
    state_t               state_reg;
    state_t               state_next;
    action_t              action_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [VALUE_W-1:0]   value_reg;
    logic [FILL_W-1:0]    fill_reg;
    logic [FILL_W-1:0]    fill_next;
    logic [FILL_W-1:0]    way_reg;
    logic [FILL_W-1:0]    way_next;
    status_t              status_reg;
    status_t              status_next;
    logic [VALUE_W-1:0]   found_reg;
    logic [VALUE_W-1:0]   found_next;

    // Response output register
    logic                 rsp_valid_reg;
    status_t              rsp_status_reg;
    logic [VALUE_W-1:0]   rsp_found_reg;
    logic                 rsp_load;

    // Hash unit
    logic                 hash_start;
    logic                 hash_done;
    logic [BUCKET_W-1:0]  bucket;

    // Entry memories, one read and one write port each
    logic [KEY_W-1:0]     key_mem [DEPTH];
    logic [VALUE_W-1:0]   val_mem [DEPTH];
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_wr_addr;
    logic [ADDR_W-1:0]    mem_rd_addr;
    logic [FILL_W-1:0]    rd_way;
    logic [KEY_W-1:0]     rd_key_reg;
    logic [VALUE_W-1:0]   rd_val_reg;

    // Bucket fill memory with per-bucket valid bits
    logic [FILL_W-1:0]       fill_mem [BUCKET_COUNT];
    logic [BUCKET_COUNT-1:0] fill_valid_reg;
    logic                    fill_we;
    logic [FILL_W-1:0]       fill_wdata;
    logic [FILL_W-1:0]       fill_rd_reg;
    logic                    fill_rd_valid_reg;
    logic [FILL_W-1:0]       fill_cur;

    logic                    req_xfer;
    logic                    key_hit;

    function automatic logic [ADDR_W-1:0] slot_addr(
        input logic [BUCKET_W-1:0] b,
        input logic [FILL_W-1:0]   w
    );
        return ADDR_W'(b) * WAYS_A + ADDR_W'(w);
    endfunction

    hkv_hash u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (hash_start),
        .key    (req.key),
        .done   (hash_done),
        .bucket (bucket)
    );

    assign req.ready  = (state_reg == S_IDLE);
    assign req_xfer   = req.valid && req.ready;
    assign hash_start = req_xfer;

    // A bucket never written since reset reads empty.
    assign fill_cur = fill_rd_valid_reg ? fill_rd_reg : '0;
    assign key_hit  = (rd_key_reg == key_reg);

    // Read one way ahead while shifting entries forward on remove.
    assign rd_way      = (state_reg == S_SHIFT) ? (way_reg + FILL_W'(1)) : way_reg;
    assign mem_rd_addr = slot_addr(bucket, rd_way);

    // ------------------------------------------------------------------------
    // Sequencer: next state, memory writes and result
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        way_next    = way_reg;
        status_next = status_reg;
        found_next  = found_reg;
        mem_we      = 1'b0;
        mem_wr_addr = slot_addr(bucket, way_reg);
        fill_we     = 1'b0;
        fill_wdata  = fill_cur + FILL_W'(1);
        rsp_load    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    status_next = ST_NOT_FOUND;
                    found_next  = '0;
                    state_next  = S_HASH;
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                // fill memory read of the bucket lands this cycle
                state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                fill_next = fill_cur;
                way_next  = '0;
                unique case (action_reg)
                    ACT_ADD:
                    begin
                        if (fill_cur >= WAYS_F)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            // append at the tail
                            mem_we      = 1'b1;
                            mem_wr_addr = slot_addr(bucket, fill_cur);
                            fill_we     = 1'b1;
                            fill_wdata  = fill_cur + FILL_W'(1);
                            status_next = ST_OK;
                        end
                        state_next = S_DONE;
                    end
                    ACT_REMOVE, ACT_LOOKUP:
                    begin
                        if (fill_cur == '0)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SEARCH;
                        end
                    end
                    ACT_NONE:
                    begin
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SEARCH:
            begin
                // key and value of way_reg are read at this edge
                state_next = S_COMPARE;
            end
            S_COMPARE:
            begin
                if (key_hit)
                begin
                    if (action_reg == ACT_LOOKUP)
                    begin
                        status_next = ST_OK;
                        found_next  = rd_val_reg;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SHIFT;
                    end
                end
                else if ((way_reg + FILL_W'(1)) >= fill_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    way_next   = way_reg + FILL_W'(1);
                    state_next = S_SEARCH;
                end
            end
            S_SHIFT:
            begin
                if ((way_reg + FILL_W'(1)) < fill_reg)
                begin
                    state_next = S_MOVE;
                end
                else
                begin
                    // tail reached: shrink the bucket
                    fill_we     = 1'b1;
                    fill_wdata  = fill_reg - FILL_W'(1);
                    status_next = ST_OK;
                    state_next  = S_DONE;
                end
            end
            S_MOVE:
            begin
                // move the later entry one way forward
                mem_we      = 1'b1;
                mem_wr_addr = slot_addr(bucket, way_reg);
                way_next    = way_reg + FILL_W'(1);
                state_next  = S_SHIFT;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rsp_valid_reg  <= 1'b0;
            fill_valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (fill_we)
            begin
                fill_valid_reg[bucket] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            action_reg <= action_t'(req.action);
            key_reg    <= req.key;
            value_reg  <= req.value;
        end
        fill_reg   <= fill_next;
        way_reg    <= way_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        if (rsp_load)
        begin
            rsp_status_reg <= status_reg;
            rsp_found_reg  <= found_reg;
        end
    end

    // Entry memories: add writes the request; a move copies the read-back entry.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[mem_wr_addr] <= (state_reg == S_MOVE) ? rd_key_reg : key_reg;
            val_mem[mem_wr_addr] <= (state_reg == S_MOVE) ? rd_val_reg : value_reg;
        end
        rd_key_reg <= key_mem[mem_rd_addr];
        rd_val_reg <= val_mem[mem_rd_addr];
    end

    // Bucket fill memory
    always_ff @(posedge clk)
    begin
        if (fill_we)
        begin
            fill_mem[bucket] <= fill_wdata;
        end
        fill_rd_reg <= fill_mem[bucket];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_rd_valid_reg <= 1'b0;
        end
        else
        begin
            fill_rd_valid_reg <= fill_valid_reg[bucket];
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.found_value = rsp_found_reg;

endmodule

/* hdl/hkv_checker.sv */
// ----------------------------------------------------------------------------
// hkv_checker
// Port-level checks on the key/value store, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hkv_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  rsp_status,
    input logic [63:0] rsp_found_value
);
    import hkv_pkg::*;

    // hold a stalled response
    `HKV_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
    `HKV_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_status) && $stable(rsp_found_value))
    // a nonzero value only comes with success
    `HKV_ASSERT_NOW(a_found_ok, rsp_valid && (rsp_found_value != '0), rsp_status == ST_OK)
    // one request at a time: ready drops after a transfer
    `HKV_ASSERT_NEXT(a_req_busy, req_valid && req_ready, !req_ready)

endmodule

bind hashed_key_value_store_top hkv_checker u_hkv_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_found_value (rsp.found_value)
);

/* tb/tb_hashed_key_value_store_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hashed_key_value_store_top
// Drives add, remove and lookup requests into the hashed key/value store and
// checks every response against a shadow copy of the buckets kept here. Most
// requests go to a few crowded buckets, so fills, full buckets, duplicates
// and shifting removes show up often. Both handshakes idle at random, and the
// response side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_hashed_key_value_store_top;

    import hkv_pkg::*;

    localparam int WAYS          = 4;
    localparam int RANDOM_ITEMS  = 650;
    localparam int HOT_BUCKETS   = 6;
    localparam int KEYS_PER_HOT  = 6;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 40;

    typedef struct {
        action_t        action;
        logic [63:0]    key;
        logic [63:0]    value;
    } kv_request_t;

    typedef struct {
        status_t        status;
        logic [63:0]    value;
    } kv_reply_t;

    logic clk = 1'b0;
    logic rst_n;

    hkv_req_if req_ch ();
    hkv_rsp_if rsp_ch ();

    hashed_key_value_store_top #(
        .BUCKET_WAYS(WAYS)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Free-running clock, 20 ns period.
    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // Shadow store: what the buckets should hold after every accepted request.
    // ------------------------------------------------------------------------
    logic [63:0] shadow_key [BUCKET_COUNT][WAYS];
    logic [63:0] shadow_val [BUCKET_COUNT][WAYS];
    int          shadow_fill [BUCKET_COUNT];

    kv_request_t request_backlog [$];
    kv_reply_t   pending_replies [$];
    kv_request_t in_flight_req;
    kv_reply_t   reply;
    kv_reply_t   due;

    int unsigned total_items  = 0;
    int unsigned req_accepted = 0;
    int unsigned fail_count   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned hold_left    = 0;
    bit          hold_done    = 1'b0;

    // Fold the key's bytes, lowest first, into a 12-bit accumulator; the low
    // byte of the result is the bucket.
    function automatic logic [7:0] bucket_of(input logic [63:0] k);
        logic [11:0] acc;
        logic [11:0] top;
        acc = '0;
        for (int i = 0; i < 8; i++)
        begin
            acc = (acc << 4) + {4'h0, k[8*i +: 8]};
            top = acc & HASH_TOP_MASK;
            if (top != '0)
            begin
                acc = acc ^ (top >> HASH_FOLD_SHIFT) ^ top;
            end
        end
        return acc[7:0];
    endfunction

    // Draw random keys until one lands in the wanted bucket.
    function automatic logic [63:0] key_in_bucket(input logic [7:0] b);
        logic [63:0] k;
        do
        begin
            k = {$urandom, $urandom};
        end
        while (bucket_of(k) != b);
        return k;
    endfunction

    // Apply one request to the shadow store and work out its response.
    task automatic apply_to_shadow(input kv_request_t r, output kv_reply_t rep);
        logic [7:0] b;
        int         hit;
        int         n;
        b   = bucket_of(r.key);
        n   = shadow_fill[b];
        hit = -1;
        rep.status = ST_NOT_FOUND;
        rep.value  = '0;
        for (int w = 0; w < n; w++)
        begin
            if (hit < 0 && shadow_key[b][w] == r.key)
            begin
                hit = w;
            end
        end
        case (r.action)
            ACT_ADD:
            begin
                if (n >= WAYS)
                begin
                    rep.status = ST_FULL;
                end
                else
                begin
                    shadow_key[b][n] = r.key;
                    shadow_val[b][n] = r.value;
                    shadow_fill[b]   = n + 1;
                    rep.status       = ST_OK;
                end
            end
            ACT_REMOVE:
            begin
                if (hit >= 0)
                begin
                    // Close the gap: later entries move one way forward.
                    for (int w = hit; w + 1 < n; w++)
                    begin
                        shadow_key[b][w] = shadow_key[b][w+1];
                        shadow_val[b][w] = shadow_val[b][w+1];
                    end
                    shadow_fill[b] = n - 1;
                    rep.status     = ST_OK;
                end
            end
            ACT_LOOKUP:
            begin
                if (hit >= 0)
                begin
                    rep.status = ST_OK;
                    rep.value  = shadow_val[b][hit];
                end
            end
            default:
            begin
                // Unused code: nothing changes, reported as a miss.
            end
        endcase
    endtask

    task automatic queue_request(input action_t a, input logic [63:0] k,
                                 input logic [63:0] v);
        kv_request_t r;
        r.action = a;
        r.key    = k;
        r.value  = v;
        request_backlog.push_back(r);
    endtask

    // Idle rates by run phase: sender 27 / receiver 55 in the first third,
    // swapped in the second, none in the last.
    function automatic int phase_of();
        if (total_items == 0)
        begin
            return 0;
        end
        return (req_accepted * 3) / total_items;
    endfunction

    function automatic int sender_idle_pct();
        case (phase_of())
            0:       return 27;
            1:       return 55;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_idle_pct();
        case (phase_of())
            0:       return 55;
            1:       return 27;
            default: return 0;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: predict on every transfer, then offer the next item or
    // idle. Hold the payload steady while a transfer is pending.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid  <= 1'b0;
            req_ch.action <= ACT_NONE;
            req_ch.key    <= '0;
            req_ch.value  <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                apply_to_shadow(in_flight_req, reply);
                pending_replies.push_back(reply);
                req_accepted++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (request_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct())
                begin
                    in_flight_req = request_backlog.pop_front();
                    req_ch.valid  <= 1'b1;
                    req_ch.action <= in_flight_req.action;
                    req_ch.key    <= in_flight_req.key;
                    req_ch.value  <= in_flight_req.value;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response monitor: check each transfer against the oldest prediction and
    // drive ready. Once, at the start of the no-idle phase, hold ready low for
    // a long stretch so the block backs up and stalls its request side.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_replies.size() == 0)
                begin
                    $error("response transfer with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    due = pending_replies.pop_front();
                    if (rsp_ch.status !== due.status)
                    begin
                        $error("status: expected %0d, got %0d", due.status, rsp_ch.status);
                        fail_count++;
                    end
                    if (rsp_ch.found_value !== due.value)
                    begin
                        $error("found_value: expected %h, got %h",
                               due.value, rsp_ch.found_value);
                        fail_count++;
                    end
                end
            end
            if (!hold_done && phase_of() >= 2)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct());
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if no transfer happens on either side for too long.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial
    begin
        logic [7:0]  zero_bucket;
        logic [63:0] key_a;
        logic [63:0] key_b;
        logic [63:0] key_c;
        logic [7:0]  hot_bucket [HOT_BUCKETS];
        logic [63:0] hot_key [HOT_BUCKETS][KEYS_PER_HOT];
        logic [63:0] k;
        int          pick;
        action_t     a;

        // Drive every block input to a known value from time zero.
        rst_n         = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.action = ACT_NONE;
        req_ch.key    = '0;
        req_ch.value  = '0;
        rsp_ch.ready  = 1'b0;
        for (int b = 0; b < BUCKET_COUNT; b++)
        begin
            shadow_fill[b] = 0;
        end

        // Directed part: three more keys sharing the bucket of key zero, so
        // that bucket can be filled, overfilled and shifted.
        zero_bucket = bucket_of(64'h0);
        key_a = key_in_bucket(zero_bucket);
        key_b = key_in_bucket(zero_bucket);
        key_c = key_in_bucket(zero_bucket);

        queue_request(ACT_LOOKUP, 64'h0, 64'h0);               // miss on empty bucket
        queue_request(ACT_REMOVE, 64'h0, '1);                  // remove miss
        queue_request(ACT_ADD,    64'h0, '1);
        queue_request(ACT_ADD,    key_a, 64'h0);
        queue_request(ACT_ADD,    64'h0, 64'h5555_5555_5555_5555); // duplicate key
        queue_request(ACT_ADD,    key_b, {$urandom, $urandom});
        queue_request(ACT_ADD,    key_c, 64'haaaa_aaaa_aaaa_aaaa); // bucket full
        queue_request(ACT_LOOKUP, 64'h0, 64'h0);               // oldest duplicate wins
        queue_request(ACT_LOOKUP, key_b, 64'h0);
        queue_request(ACT_REMOVE, key_a, 64'h0);               // middle entry, shift
        queue_request(ACT_LOOKUP, key_b, 64'h0);
        queue_request(ACT_ADD,    key_c, 64'haaaa_aaaa_aaaa_aaaa);
        queue_request(ACT_REMOVE, 64'h0, 64'h0);               // drops oldest duplicate
        queue_request(ACT_LOOKUP, 64'h0, 64'h0);
        queue_request(ACT_NONE,   64'h0, 64'h0);               // unused action code
        queue_request(ACT_ADD,    '1, '1);
        queue_request(ACT_LOOKUP, '1, 64'h0);
        queue_request(ACT_LOOKUP, key_c, '1);                  // tail entry
        queue_request(ACT_REMOVE, key_c, 64'h0);               // tail remove, no shift
        queue_request(ACT_REMOVE, '1, 64'h0);
        queue_request(ACT_LOOKUP, '1, 64'h0);
        queue_request(ACT_NONE,   '1, '1);

        // Random part: crowd a few buckets with a small key pool so hits,
        // duplicates, full buckets and shifts are common; mix in stray keys.
        for (int h = 0; h < HOT_BUCKETS; h++)
        begin
            hot_bucket[h] = $urandom_range(BUCKET_COUNT - 1);
            for (int j = 0; j < KEYS_PER_HOT; j++)
            begin
                hot_key[h][j] = key_in_bucket(hot_bucket[h]);
            end
        end
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ($urandom_range(99) < 85)
            begin
                k = hot_key[$urandom_range(HOT_BUCKETS - 1)][$urandom_range(KEYS_PER_HOT - 1)];
            end
            else
            begin
                k = {$urandom, $urandom};
            end
            pick = $urandom_range(99);
            if (pick < 36)
            begin
                a = ACT_ADD;
            end
            else if (pick < 64)
            begin
                a = ACT_REMOVE;
            end
            else if (pick < 95)
            begin
                a = ACT_LOOKUP;
            end
            else
            begin
                a = ACT_NONE;
            end
            queue_request(a, k, {$urandom, $urandom});
        end
        total_items = request_backlog.size();

        // Hold reset, then release it away from the active edge.
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for every request to transfer and every response to arrive,
        // then let a few latencies pass to catch stray responses.
        while (req_accepted != total_items)
        begin
            @(posedge clk);
        end
        while (pending_replies.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
